>>> hdl/gas_pkg.sv
// ============================================================================
// gas_pkg - shared constants for the grid path search block
// Default geometry, request function codes and result status codes.
// ============================================================================
package gas_pkg;

    localparam int DEF_GRID_WIDTH  = 32;
    localparam int DEF_GRID_HEIGHT = 32;
    localparam int DEF_OPEN_DEPTH  = 1024;

    // request function codes
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;   // unused, acked only

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_NOPATH   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

endpackage

>>> hdl/grid_astar_path_search.sv
// ============================================================================
// grid_astar_path_search - A* path search over a walkability grid
// Holds a one-bit map, runs 4-connected searches and serves the stored path.
// ============================================================================
// Usage:
//   A request is taken on a rising edge with start high and busy low. func
//   picks the operation: write one cell of the map, run a search from
//   (cell_x, cell_y) to (goal_x, goal_y), or read entry step_index of the
//   stored path. Every request gives exactly one result: done is high for
//   one cycle with status, path_length, step_x and step_y valid. The
//   receiver cannot stall; a result must be taken in that cycle.
// Sequence:
//   write and unused codes finish straight from idle; a path read first
//   reads the route RAM. A search clears the per-cell node table, then
//   expands cells, popping the best entry from the open heap and pushing
//   improved neighbours, then walks the back links to count the path
//   cells and writes the route.
//   Everything runs through one single-port heap RAM and one node RAM under
//   a sequencer, so busy stays high for the whole search.
// Reset:
//   after rst_n is released the block sweeps the walkability map to blocked,
//   with busy high. The stored path is empty.
// ============================================================================
module grid_astar_path_search #(
    parameter int GRID_WIDTH  = gas_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = gas_pkg::DEF_GRID_HEIGHT,
    parameter int OPEN_DEPTH  = gas_pkg::DEF_OPEN_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [4:0]  cell_x,
    input  logic [4:0]  cell_y,
    input  logic        walkable,
    input  logic [4:0]  goal_x,
    input  logic [4:0]  goal_y,
    input  logic [9:0]  step_index,
    output logic        done,
    output logic [2:0]  status,
    output logic [10:0] path_length,
    output logic [4:0]  step_x,
    output logic [4:0]  step_y
);

    localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int CW     = $clog2(NCELLS);
    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);
    localparam int PW     = XW + YW;                 // packed {y, x}
    localparam int GW     = $clog2(NCELLS + 1);      // path cost
    localparam int FW     = $clog2(NCELLS + GRID_WIDTH + GRID_HEIGHT);
    localparam int CNTW   = $clog2(OPEN_DEPTH + 1);
    localparam int IW     = $clog2(OPEN_DEPTH);
    localparam int LW     = CNTW + 1;
    localparam int HW     = FW + GW + PW;            // heap entry {f, g, pos}
    localparam int NW     = 1 + GW + PW;             // node {seen, cost, link}

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_WCLR  = 5'd1;
    localparam logic [4:0] S_NCLR  = 5'd2;
    localparam logic [4:0] S_SINIT = 5'd3;
    localparam logic [4:0] S_PUSH  = 5'd4;
    localparam logic [4:0] S_PCHK  = 5'd5;
    localparam logic [4:0] S_PCMP  = 5'd6;
    localparam logic [4:0] S_POP   = 5'd7;
    localparam logic [4:0] S_POP1  = 5'd8;
    localparam logic [4:0] S_POP2  = 5'd9;
    localparam logic [4:0] S_SIFT  = 5'd10;
    localparam logic [4:0] S_SIFTL = 5'd11;
    localparam logic [4:0] S_SIFTR = 5'd12;
    localparam logic [4:0] S_SIFTD = 5'd13;
    localparam logic [4:0] S_EXP   = 5'd14;
    localparam logic [4:0] S_EXPG  = 5'd15;
    localparam logic [4:0] S_NB    = 5'd16;
    localparam logic [4:0] S_NBCHK = 5'd17;
    localparam logic [4:0] S_NEXT  = 5'd18;
    localparam logic [4:0] S_RT1   = 5'd19;
    localparam logic [4:0] S_RT2   = 5'd20;
    localparam logic [4:0] S_RT3   = 5'd21;
    localparam logic [4:0] S_RT4   = 5'd22;
    localparam logic [4:0] S_RT5   = 5'd23;
    localparam logic [4:0] S_RD1   = 5'd24;

    // neighbor order: y+1, y-1, x+1, x-1
    localparam logic [1:0] DIR_YP = 2'd0;
    localparam logic [1:0] DIR_YM = 2'd1;
    localparam logic [1:0] DIR_XP = 2'd2;
    localparam logic [1:0] DIR_XM = 2'd3;

    function automatic logic [CW-1:0] cell_of(input logic [PW-1:0] pos);
        cell_of = CW'(32'(pos[PW-1:XW]) * GRID_WIDTH + 32'(pos[XW-1:0]));
    endfunction

    function automatic logic [FW-1:0] heur(input logic [PW-1:0] a,
                                           input logic [PW-1:0] b);
        logic [XW-1:0] dx;
        logic [YW-1:0] dy;
        dx = (a[XW-1:0] > b[XW-1:0]) ? a[XW-1:0] - b[XW-1:0] : b[XW-1:0] - a[XW-1:0];
        dy = (a[PW-1:XW] > b[PW-1:XW]) ? a[PW-1:XW] - b[PW-1:XW]
                                       : b[PW-1:XW] - a[PW-1:XW];
        heur = FW'(dx) + FW'(dy);
    endfunction

    // heap order: smaller f, then larger g, then smaller cell index
    function automatic logic first(input logic [HW-1:0] a, input logic [HW-1:0] b);
        logic [FW-1:0] fa, fb;
        logic [GW-1:0] ga, gb;
        fa = a[HW-1 -: FW];
        fb = b[HW-1 -: FW];
        ga = a[PW+GW-1 -: GW];
        gb = b[PW+GW-1 -: GW];
        if (fa != fb)
        begin
            first = fa < fb;
        end
        else if (ga != gb)
        begin
            first = ga > gb;
        end
        else
        begin
            first = a[PW-1:0] < b[PW-1:0];
        end
    endfunction

    // control registers
    logic [4:0]      state_reg, state_next;
    logic [CW-1:0]   sweep_reg, sweep_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [GW-1:0]   rcount_reg, rcount_next;
    logic            done_reg, done_next;

    // working registers
    logic [PW-1:0]   spos_reg, spos_next;
    logic [PW-1:0]   gpos_reg, gpos_next;
    logic [IW-1:0]   hi_reg, hi_next;
    logic [IW-1:0]   pi_reg, pi_next;
    logic [IW-1:0]   mi_reg, mi_next;
    logic [HW-1:0]   ent_reg, ent_next;
    logic [HW-1:0]   top_reg, top_next;
    logic [HW-1:0]   last_reg, last_next;
    logic [HW-1:0]   lent_reg, lent_next;
    logic [HW-1:0]   mx_reg, mx_next;
    logic [GW-1:0]   curg_reg, curg_next;
    logic [PW-1:0]   cur_reg, cur_next;
    logic [PW-1:0]   nb_reg, nb_next;
    logic [1:0]      dir_reg, dir_next;
    logic            retpop_reg, retpop_next;
    logic [PW-1:0]   k_reg, k_next;
    logic [GW-1:0]   len_reg, len_next;
    logic [2:0]      status_reg, status_next;
    logic [4:0]      stx_reg, stx_next;
    logic [4:0]      sty_reg, sty_next;

    // memory ports
    logic            walk_we, walk_wd, walk_rd;
    logic [CW-1:0]   walk_addr;
    logic            node_we;
    logic [CW-1:0]   node_addr;
    logic [NW-1:0]   node_wd, node_rd;
    logic            heap_we;
    logic [IW-1:0]   heap_addr;
    logic [HW-1:0]   heap_wd, heap_rd;
    logic            route_we;
    logic [CW-1:0]   route_addr;
    logic [PW-1:0]   route_wd, route_rd;

    gas_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_walk (
        .clk(clk), .we(walk_we), .addr(walk_addr), .wdata(walk_wd), .rdata(walk_rd)
    );
    gas_ram #(.WIDTH(NW), .DEPTH(NCELLS)) u_node (
        .clk(clk), .we(node_we), .addr(node_addr), .wdata(node_wd), .rdata(node_rd)
    );
    gas_ram #(.WIDTH(HW), .DEPTH(OPEN_DEPTH)) u_heap (
        .clk(clk), .we(heap_we), .addr(heap_addr), .wdata(heap_wd), .rdata(heap_rd)
    );
    gas_ram #(.WIDTH(PW), .DEPTH(NCELLS)) u_route (
        .clk(clk), .we(route_we), .addr(route_addr), .wdata(route_wd), .rdata(route_rd)
    );

    // derived values
    logic            accept;
    logic            in_grid;
    logic [PW-1:0]   in_spos, in_gpos;
    logic [LW-1:0]   lw, rw;
    logic [IW-1:0]   hi_m1;
    logic [CNTW-1:0] cnt_dec;
    logic [GW-1:0]   ng;
    logic            fin;
    logic [2:0]      fin_status;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign in_spos = {YW'(cell_y), XW'(cell_x)};
    assign in_gpos = {YW'(goal_y), XW'(goal_x)};
    assign in_grid = (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);
    assign lw      = LW'({hi_reg, 1'b1});
    assign rw      = lw + LW'(1);
    assign hi_m1   = hi_reg - IW'(1);
    assign cnt_dec = cnt_reg - CNTW'(1);
    assign ng      = curg_reg + GW'(1);

    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        cnt_next    = cnt_reg;
        rcount_next = rcount_reg;
        done_next   = 1'b0;
        spos_next   = spos_reg;
        gpos_next   = gpos_reg;
        hi_next     = hi_reg;
        pi_next     = pi_reg;
        mi_next     = mi_reg;
        ent_next    = ent_reg;
        top_next    = top_reg;
        last_next   = last_reg;
        lent_next   = lent_reg;
        mx_next     = mx_reg;
        curg_next   = curg_reg;
        cur_next    = cur_reg;
        nb_next     = nb_reg;
        dir_next    = dir_reg;
        retpop_next = retpop_reg;
        k_next      = k_reg;
        len_next    = len_reg;
        status_next = status_reg;
        stx_next    = stx_reg;
        sty_next    = sty_reg;

        walk_we    = 1'b0;
        walk_wd    = 1'b0;
        walk_addr  = cell_of(nb_reg);
        node_we    = 1'b0;
        node_wd    = '0;
        node_addr  = cell_of(nb_reg);
        heap_we    = 1'b0;
        heap_wd    = ent_reg;
        heap_addr  = hi_reg;
        route_we   = 1'b0;
        route_wd   = k_reg;
        route_addr = CW'(len_reg - GW'(1));

        fin        = 1'b0;
        fin_status = gas_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        gas_pkg::FUNC_WRITE:
                        begin
                            walk_we   = in_grid;
                            walk_wd   = walkable;
                            walk_addr = cell_of(in_spos);
                            fin       = 1'b1;
                        end
                        gas_pkg::FUNC_SEARCH:
                        begin
                            cnt_next    = '0;
                            rcount_next = '0;
                            spos_next   = in_spos;
                            gpos_next   = in_gpos;
                            sweep_next  = '0;
                            if (in_grid && (32'(goal_x) < GRID_WIDTH)
                                && (32'(goal_y) < GRID_HEIGHT))
                            begin
                                state_next = S_NCLR;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = gas_pkg::ST_NOPATH;
                            end
                        end
                        gas_pkg::FUNC_READ:
                        begin
                            if (32'(step_index) < 32'(rcount_reg))
                            begin
                                route_addr = CW'(step_index);
                                state_next = S_RD1;
                            end
                            else
                            begin
                                fin        = 1'b1;
                                fin_status = gas_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_WCLR:
            begin
                // post-reset sweep: whole map blocked
                walk_we    = 1'b1;
                walk_addr  = sweep_reg;
                sweep_next = sweep_reg + CW'(1);
                if (sweep_reg == CW'(NCELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_NCLR:
            begin
                // clear seen marks of the node table
                node_we    = 1'b1;
                node_addr  = sweep_reg;
                sweep_next = sweep_reg + CW'(1);
                if (sweep_reg == CW'(NCELLS - 1))
                begin
                    state_next = S_SINIT;
                end
            end
            S_SINIT:
            begin
                node_we     = 1'b1;
                node_addr   = cell_of(spos_reg);
                node_wd     = {1'b1, GW'(0), spos_reg};
                ent_next    = {heur(spos_reg, gpos_reg), GW'(0), spos_reg};
                retpop_next = 1'b1;
                state_next  = S_PUSH;
            end
            S_PUSH:
            begin
                if (cnt_reg == CNTW'(OPEN_DEPTH))
                begin
                    cnt_next   = '0;
                    fin        = 1'b1;
                    fin_status = gas_pkg::ST_OVERFLOW;
                end
                else
                begin
                    hi_next    = IW'(cnt_reg);
                    cnt_next   = cnt_reg + CNTW'(1);
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (hi_reg == '0)
                begin
                    heap_we    = 1'b1;
                    state_next = retpop_reg ? S_POP : S_NEXT;
                end
                else
                begin
                    heap_addr  = {1'b0, hi_m1[IW-1:1]};
                    pi_next    = {1'b0, hi_m1[IW-1:1]};
                    state_next = S_PCMP;
                end
            end
            S_PCMP:
            begin
                heap_we = 1'b1;
                if (first(ent_reg, heap_rd))
                begin
                    heap_wd    = heap_rd;
                    hi_next    = pi_reg;
                    state_next = S_PCHK;
                end
                else
                begin
                    state_next = retpop_reg ? S_POP : S_NEXT;
                end
            end
            S_POP:
            begin
                if (cnt_reg == '0)
                begin
                    fin        = 1'b1;
                    fin_status = gas_pkg::ST_NOPATH;
                end
                else
                begin
                    heap_addr  = '0;
                    state_next = S_POP1;
                end
            end
            S_POP1:
            begin
                top_next = heap_rd;
                cnt_next = cnt_dec;
                if (cnt_dec == '0)
                begin
                    state_next = S_EXP;
                end
                else
                begin
                    heap_addr  = IW'(cnt_dec);
                    state_next = S_POP2;
                end
            end
            S_POP2:
            begin
                last_next  = heap_rd;
                hi_next    = '0;
                state_next = S_SIFT;
            end
            S_SIFT:
            begin
                if (lw >= LW'(cnt_reg))
                begin
                    heap_we    = 1'b1;
                    heap_wd    = last_reg;
                    state_next = S_EXP;
                end
                else
                begin
                    heap_addr  = IW'(lw);
                    state_next = S_SIFTL;
                end
            end
            S_SIFTL:
            begin
                lent_next = heap_rd;
                if (rw < LW'(cnt_reg))
                begin
                    heap_addr  = IW'(rw);
                    state_next = S_SIFTR;
                end
                else
                begin
                    mx_next    = heap_rd;
                    mi_next    = IW'(lw);
                    state_next = S_SIFTD;
                end
            end
            S_SIFTR:
            begin
                if (first(heap_rd, lent_reg))
                begin
                    mx_next = heap_rd;
                    mi_next = IW'(rw);
                end
                else
                begin
                    mx_next = lent_reg;
                    mi_next = IW'(lw);
                end
                state_next = S_SIFTD;
            end
            S_SIFTD:
            begin
                heap_we = 1'b1;
                if (first(mx_reg, last_reg))
                begin
                    heap_wd    = mx_reg;
                    hi_next    = mi_reg;
                    state_next = S_SIFT;
                end
                else
                begin
                    heap_wd    = last_reg;
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                if (top_reg[PW-1:0] == gpos_reg)
                begin
                    len_next   = GW'(1);
                    k_next     = gpos_reg;
                    state_next = S_RT1;
                end
                else
                begin
                    node_addr  = cell_of(top_reg[PW-1:0]);
                    state_next = S_EXPG;
                end
            end
            S_EXPG:
            begin
                // expand from the stored best cost, not the popped g
                curg_next  = node_rd[NW-2 -: GW];
                cur_next   = top_reg[PW-1:0];
                dir_next   = DIR_YP;
                state_next = S_NB;
            end
            S_NB:
            begin
                logic          ok;
                logic [XW-1:0] nx;
                logic [YW-1:0] ny;
                nx = cur_reg[XW-1:0];
                ny = cur_reg[PW-1:XW];
                unique case (dir_reg)
                    DIR_YP:
                    begin
                        ok = (ny != YW'(GRID_HEIGHT - 1));
                        ny = ny + YW'(1);
                    end
                    DIR_YM:
                    begin
                        ok = (ny != '0);
                        ny = ny - YW'(1);
                    end
                    DIR_XP:
                    begin
                        ok = (nx != XW'(GRID_WIDTH - 1));
                        nx = nx + XW'(1);
                    end
                    default:
                    begin
                        ok = (nx != '0);
                        nx = nx - XW'(1);
                    end
                endcase
                nb_next   = {ny, nx};
                walk_addr = cell_of({ny, nx});
                node_addr = cell_of({ny, nx});
                state_next = ok ? S_NBCHK : S_NEXT;
            end
            S_NBCHK:
            begin
                if (walk_rd && (!node_rd[NW-1] || (ng < node_rd[NW-2 -: GW])))
                begin
                    node_we     = 1'b1;
                    node_wd     = {1'b1, ng, cur_reg};
                    ent_next    = {FW'(ng) + heur(nb_reg, gpos_reg), ng, nb_reg};
                    retpop_next = 1'b0;
                    state_next  = S_PUSH;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                dir_next   = dir_reg + 2'd1;
                state_next = (dir_reg == DIR_XM) ? S_POP : S_NB;
            end
            S_RT1:
            begin
                // walk back links to count the path
                if ((k_reg == spos_reg) || (len_reg >= GW'(NCELLS)))
                begin
                    state_next = S_RT3;
                end
                else
                begin
                    node_addr  = cell_of(k_reg);
                    state_next = S_RT2;
                end
            end
            S_RT2:
            begin
                k_next     = node_rd[PW-1:0];
                len_next   = len_reg + GW'(1);
                state_next = S_RT1;
            end
            S_RT3:
            begin
                rcount_next = len_reg;
                k_next      = gpos_reg;
                state_next  = S_RT4;
            end
            S_RT4:
            begin
                // fill the route from the goal end down to the start
                route_we   = 1'b1;
                node_addr  = cell_of(k_reg);
                len_next   = len_reg - GW'(1);
                state_next = S_RT5;
            end
            S_RT5:
            begin
                k_next = node_rd[PW-1:0];
                if (len_reg == '0)
                begin
                    fin        = 1'b1;
                    fin_status = gas_pkg::ST_FOUND;
                end
                else
                begin
                    state_next = S_RT4;
                end
            end
            S_RD1:
            begin
                fin = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            status_next = fin_status;
            stx_next    = '0;
            sty_next    = '0;
            if (state_reg == S_RD1)
            begin
                stx_next = 5'(route_rd[XW-1:0]);
                sty_next = 5'(route_rd[PW-1:XW]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_WCLR;
            sweep_reg  <= '0;
            cnt_reg    <= '0;
            rcount_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            cnt_reg    <= cnt_next;
            rcount_reg <= rcount_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        spos_reg   <= spos_next;
        gpos_reg   <= gpos_next;
        hi_reg     <= hi_next;
        pi_reg     <= pi_next;
        mi_reg     <= mi_next;
        ent_reg    <= ent_next;
        top_reg    <= top_next;
        last_reg   <= last_next;
        lent_reg   <= lent_next;
        mx_reg     <= mx_next;
        curg_reg   <= curg_next;
        cur_reg    <= cur_next;
        nb_reg     <= nb_next;
        dir_reg    <= dir_next;
        retpop_reg <= retpop_next;
        k_reg      <= k_next;
        len_reg    <= len_next;
        status_reg <= status_next;
        stx_reg    <= stx_next;
        sty_reg    <= sty_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign path_length = 11'(rcount_reg);
    assign step_x      = stx_reg;
    assign step_y      = sty_reg;

endmodule

>>> hdl/gas_ram.sv
// ============================================================================
// gas_ram - generic single-port RAM
// One read or write per cycle, registered read data, no reset.
// ============================================================================
module gas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> tb/grid_astar_path_search_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// grid_astar_path_search_checker - result checker for the grid path search
// Watches accepted requests, predicts each result from its own A* copy of
// the block and compares every done strobe against the oldest prediction.
// ============================================================================
module grid_astar_path_search_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  func,
    input  logic [4:0]  cell_x,
    input  logic [4:0]  cell_y,
    input  logic        walkable,
    input  logic [4:0]  goal_x,
    input  logic [4:0]  goal_y,
    input  logic [9:0]  step_index,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [10:0] path_length,
    input  logic [4:0]  step_x,
    input  logic [4:0]  step_y,
    output int          fail_count,
    output int          pending,
    output int          found_count,
    output int          longest_path
);

    localparam int GW    = 32;
    localparam int GH    = 32;
    localparam int CELLS = GW * GH;
    localparam int HEAP  = 1024;

    typedef struct {
        int f;
        int g;
        int loc;
    } open_node_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] path_length;
        logic [4:0]  step_x;
        logic [4:0]  step_y;
    } reply_t;

    bit         walk_bits [CELLS];
    bit         visited   [CELLS];
    int         cost_to   [CELLS];
    int         came_from [CELLS];
    open_node_t frontier  [HEAP];
    int         frontier_n;
    int         route     [CELLS];
    int         route_n;
    reply_t     replies_due [$];

    function automatic bit pops_first(open_node_t a, open_node_t b);
        if (a.f != b.f) return a.f < b.f;
        if (a.g != b.g) return a.g > b.g;
        return a.loc < b.loc;
    endfunction

    function automatic bit frontier_push(open_node_t e);
        int i;
        int p;
        if (frontier_n >= HEAP) return 0;
        i = frontier_n;
        frontier_n++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!pops_first(e, frontier[p])) break;
            frontier[i] = frontier[p];
            i = p;
        end
        frontier[i] = e;
        return 1;
    endfunction

    function automatic open_node_t frontier_pop();
        open_node_t top;
        open_node_t last;
        int i;
        int l;
        int m;
        top = frontier[0];
        frontier_n--;
        if (frontier_n == 0) return top;
        last = frontier[frontier_n];
        i = 0;
        forever begin
            l = 2 * i + 1;
            if (l >= frontier_n) break;
            m = l;
            if (l + 1 < frontier_n && pops_first(frontier[l + 1], frontier[l])) m = l + 1;
            if (!pops_first(frontier[m], last)) break;
            frontier[i] = frontier[m];
            i = m;
        end
        frontier[i] = last;
        return top;
    endfunction

    function automatic int manhattan_len(int x, int y, int gx, int gy);
        return (x > gx ? x - gx : gx - x) + (y > gy ? y - gy : gy - y);
    endfunction

    function automatic logic [2:0] find_route(int sx, int sy, int gx, int gy);
        int src;
        int dst;
        int c;
        int g;
        int nx;
        int ny;
        int n;
        int len;
        int k;
        open_node_t e;
        open_node_t cur;
        int dx [4] = '{0, 0, 1, -1};
        int dy [4] = '{1, -1, 0, 0};
        foreach (visited[i]) visited[i] = 0;
        frontier_n = 0;
        route_n    = 0;
        src = sy * GW + sx;
        dst = gy * GW + gx;
        visited[src]   = 1;
        cost_to[src]   = 0;
        came_from[src] = src;
        e.f = manhattan_len(sx, sy, gx, gy);
        e.g = 0;
        e.loc = src;
        if (!frontier_push(e)) return gas_pkg::ST_OVERFLOW;
        while (frontier_n > 0) begin
            cur = frontier_pop();
            c = cur.loc;
            if (c == dst) begin
                len = 1;
                k = dst;
                while (k != src && len < CELLS) begin
                    k = came_from[k];
                    len++;
                end
                k = dst;
                for (int i = len; i > 0; i--) begin
                    route[i - 1] = k;
                    k = came_from[k];
                end
                route_n = len;
                return gas_pkg::ST_FOUND;
            end
            g = cost_to[c];
            for (int d = 0; d < 4; d++) begin
                nx = c % GW + dx[d];
                ny = c / GW + dy[d];
                if (nx < 0 || ny < 0 || nx >= GW || ny >= GH) continue;
                n = ny * GW + nx;
                if (!walk_bits[n]) continue;
                if (!visited[n] || g + 1 < cost_to[n]) begin
                    visited[n]   = 1;
                    cost_to[n]   = g + 1;
                    came_from[n] = c;
                    e.f = g + 1 + manhattan_len(nx, ny, gx, gy);
                    e.g = g + 1;
                    e.loc = n;
                    if (!frontier_push(e)) begin
                        frontier_n = 0;
                        return gas_pkg::ST_OVERFLOW;
                    end
                end
            end
        end
        return gas_pkg::ST_NOPATH;
    endfunction

    assign pending = replies_due.size();

    always @(posedge clk or negedge rst_n) begin
        reply_t exp_r;
        reply_t got;
        if (!rst_n) begin
            foreach (walk_bits[i]) walk_bits[i] = 0;
            route_n    = 0;
            frontier_n = 0;
            replies_due.delete();
            fail_count   <= 0;
            found_count  <= 0;
            longest_path <= 0;
        end else begin
            // result of an earlier request first, then any new request
            if (done) begin
                got = '{status, path_length, step_x, step_y};
                if (replies_due.size() == 0) begin
                    $display("%0t: result with none outstanding: status %0d len %0d",
                             $realtime, status, path_length);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = replies_due.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: mismatch expected st %0d len %0d x %0d y %0d, got st %0d len %0d x %0d y %0d",
                                 $realtime, exp_r.status, exp_r.path_length, exp_r.step_x,
                                 exp_r.step_y, got.status, got.path_length, got.step_x,
                                 got.step_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                exp_r = '{gas_pkg::ST_OK, 11'd0, 5'd0, 5'd0};
                if (func == gas_pkg::FUNC_WRITE) begin
                    walk_bits[cell_y * GW + cell_x] = walkable;
                end else if (func == gas_pkg::FUNC_SEARCH) begin
                    exp_r.status = find_route(cell_x, cell_y, goal_x, goal_y);
                    if (exp_r.status == gas_pkg::ST_FOUND) begin
                        found_count <= found_count + 1;
                        if (route_n > longest_path) longest_path <= route_n;
                    end
                end else if (func == gas_pkg::FUNC_READ) begin
                    if (step_index < route_n) begin
                        exp_r.step_x = 5'(route[step_index] % GW);
                        exp_r.step_y = 5'(route[step_index] / GW);
                    end else begin
                        exp_r.status = gas_pkg::ST_RANGE;
                    end
                end
                exp_r.path_length = 11'(route_n);
                replies_due = {replies_due, exp_r};
            end
        end
    end

endmodule

>>> tb/tb_grid_astar_path_search.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_grid_astar_path_search - testbench top for the grid path search block
// Drives directed and windowed random requests (cell writes, searches, path
// reads) with varying sender gaps; the checker predicts and compares results.
// ============================================================================
module tb_grid_astar_path_search;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic        walkable;
    logic [4:0]  goal_x;
    logic [4:0]  goal_y;
    logic [9:0]  step_index;
    logic        done;
    logic [2:0]  status;
    logic [10:0] path_length;
    logic [4:0]  step_x;
    logic [4:0]  step_y;

    int fail_count;
    int pending;
    int found_count;
    int longest_path;

    int idle_pct;        // sender gap chance for the current phase
    int request_total;
    int search_total;

    grid_astar_path_search dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .cell_x(cell_x), .cell_y(cell_y), .walkable(walkable),
        .goal_x(goal_x), .goal_y(goal_y), .step_index(step_index),
        .done(done), .status(status), .path_length(path_length),
        .step_x(step_x), .step_y(step_y)
    );

    grid_astar_path_search_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .cell_x(cell_x), .cell_y(cell_y), .walkable(walkable),
        .goal_x(goal_x), .goal_y(goal_y), .step_index(step_index),
        .done(done), .status(status), .path_length(path_length),
        .step_x(step_x), .step_y(step_y),
        .fail_count(fail_count), .pending(pending),
        .found_count(found_count), .longest_path(longest_path)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One request: optional sender gap, then hold start until an edge with
    // busy low takes it. start stays high on return, so back-to-back
    // requests never drop it within a time step.
    task automatic send_request(input logic [1:0] f, input int cx, input int cy,
                                input bit w, input int gx, input int gy, input int idx);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        cell_x     <= 5'(cx);
        cell_y     <= 5'(cy);
        walkable   <= w;
        goal_x     <= 5'(gx);
        goal_y     <= 5'(gy);
        step_index <= 10'(idx);
        do @(posedge clk); while (busy);
        request_total++;
        if (f == gas_pkg::FUNC_SEARCH) search_total++;
    endtask

    task automatic write_cell(input int x, input int y, input bit w);
        send_request(gas_pkg::FUNC_WRITE, x, y, w, $urandom_range(31), $urandom_range(31),
                     $urandom_range(1023));
    endtask

    task automatic search(input int sx, input int sy, input int gx, input int gy);
        send_request(gas_pkg::FUNC_SEARCH, sx, sy, $urandom_range(1), gx, gy,
                     $urandom_range(1023));
    endtask

    task automatic read_step(input int idx);
        send_request(gas_pkg::FUNC_READ, $urandom_range(31), $urandom_range(31),
                     $urandom_range(1), $urandom_range(31), $urandom_range(31), idx);
    endtask

    initial begin
        int ox;
        int oy;
        int n;
        int wait_cycles;
        rst_n         = 1'b0;
        start        <= 1'b0;
        func         <= gas_pkg::FUNC_WRITE;
        cell_x       <= '0;
        cell_y       <= '0;
        walkable     <= 1'b0;
        goal_x       <= '0;
        goal_y       <= '0;
        step_index   <= '0;
        idle_pct      = 0;
        request_total = 0;
        search_total  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners, trivial and blocked cases, range reads, code 3
        write_cell(0, 0, 1);
        write_cell(31, 31, 1);
        write_cell(1, 0, 1);
        write_cell(0, 1, 0);
        read_step(0);                 // empty path after reset
        search(0, 0, 0, 0);           // start equals goal
        read_step(0);
        read_step(1);                 // just past the end
        read_step(1023);
        send_request(gas_pkg::FUNC_NONE, 31, 31, 1, 31, 31, 1023);   // unused code
        write_cell(5, 6, 1);
        search(5, 5, 5, 6);           // start cell itself is blocked
        read_step(0);
        read_step(1);
        search(0, 0, 0, 1);           // blocked goal
        search(0, 0, 1, 0);
        write_cell(1, 0, 0);          // write leaves the stored path alone
        read_step(1);
        search(31, 31, 0, 0);         // walled-off goal
        read_step(0);
        search(31, 31, 31, 31);

        // random: small windows that fill in over time, searched and read
        while (request_total < 130) begin
            case ((request_total / 32) % 4)
                0: idle_pct = 0;
                1: idle_pct = 53;
                2: idle_pct = 0;
                default: idle_pct = 9;
            endcase
            ox = $urandom_range(24);
            oy = $urandom_range(24);
            n  = $urandom_range(4, 12);
            repeat (n) begin
                if ($urandom_range(9) == 0)
                    write_cell($urandom_range(31), $urandom_range(31), $urandom_range(1));
                else
                    write_cell(ox + $urandom_range(7), oy + $urandom_range(7),
                               $urandom_range(99) < 85);
            end
            if ($urandom_range(7) == 0)
                search($urandom_range(31), $urandom_range(31),
                       $urandom_range(31), $urandom_range(31));
            else
                search(ox + $urandom_range(7), oy + $urandom_range(7),
                       ox + $urandom_range(7), oy + $urandom_range(7));
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(4) == 0)
                    read_step($urandom_range(1023));
                else
                    read_step($urandom_range(15));
            end
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 400000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);

        $display("covered %0d requests, %0d searches, %0d paths found, longest %0d cells",
                 request_total, search_total, found_count, longest_path);
        if (fail_count == 0 && pending == 0)
            $display("grid_astar_path_search verification clean");
        else
            $display("grid_astar_path_search verification failed");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #200ms;
        $display("grid_astar_path_search verification failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/gas_pkg.sv
hdl/gas_ram.sv
hdl/grid_astar_path_search.sv
tb/grid_astar_path_search_checker.sv
tb/tb_grid_astar_path_search.sv
